// ===== design/mctr_pkg.sv =====
`timescale 1ns / 1ps
package mctr_pkg;

	// Buffer geometry.
	localparam int BUF_DEPTH = 4096;
	localparam int MAX_CH    = 4;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int MEM_DEPTH = MAX_CH * BUF_DEPTH;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int CH_W      = (MAX_CH > 1) ? $clog2(MAX_CH) : 1;
	localparam int OUT_CH    = 4;

	// Field and register widths.
	localparam int SMP_W      = 16;
	localparam int SCNT_W     = 13;
	localparam int NDX_W      = SCNT_W;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Shared multiplier: signed 37 x signed 18, product registered.
	localparam int MA_W   = 37;
	localparam int MB_W   = 18;
	localparam int PROD_W = MA_W + MB_W;

	// Division of the correction term by three, one byte per step.
	localparam int DIV_STEPS = 5;
	localparam int DIV_W     = 8 * DIV_STEPS;
	localparam int DIV3_MUL  = 683;
	localparam int DIV3_SH   = 11;

	// Half of 6 * 2^16, the rounding offset of the correction term.
	localparam int CORR_RND = 196608;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MS_SCALE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYABLE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_PRESENT = 3'd4;

	// Item opcodes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PLAY  = 1'b1;

	// Multiplier operand selects.
	localparam logic [2:0] MUL_NONE  = 3'd0;
	localparam logic [2:0] MUL_PH_LO = 3'd1;
	localparam logic [2:0] MUL_PH_HI = 3'd2;
	localparam logic [2:0] MUL_EF    = 3'd3;
	localparam logic [2:0] MUL_INNER = 3'd4;
	localparam logic [2:0] MUL_RF    = 3'd5;

	typedef struct packed {
		logic [23:0]       ms_scale;
		logic [SCNT_W-1:0] sample_count;
		logic              playable;
		logic [2:0]        channel_count;
		logic [3:0]        channel_present;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		ms_scale:        24'd2890138,
		sample_count:    '0,
		playable:        1'b0,
		channel_count:   3'd1,
		channel_present: 4'hF
	};

	typedef struct packed {
		logic            wr_en;
		logic            ld_pos;
		logic            clr_res;
		logic [2:0]      mul_sel;
		logic            plo_ld;
		logic            ph_ld;
		logic            rd_en;
		logic [1:0]      rd_k;
		logic [CH_W-1:0] ch;
		logic            inner_ld;
		logic            div_load;
		logic            div_step;
		logic            r_ld;
		logic            y_ld;
		logic            out_load;
	} dp_cmd_t;

	// Sample count limited to the buffer depth.
	function automatic logic [SCNT_W-1:0] eff_count(input logic [SCNT_W-1:0] n);
		if (int'(n) > BUF_DEPTH)
			return SCNT_W'(BUF_DEPTH);
		return n;
	endfunction

endpackage

// ===== design/mctr_in_if.sv =====
`timescale 1ns / 1ps
interface mctr_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [1:0]         channel;
	logic [11:0]        sample_index;
	logic signed [15:0] sample_value;
	logic signed [23:0] position_ms;

	modport source (
		output valid, op, channel, sample_index, sample_value, position_ms,
		input  ready
	);
	modport sink (
		input  valid, op, channel, sample_index, sample_value, position_ms,
		output ready
	);
endinterface

// ===== design/mctr_out_if.sv =====
`timescale 1ns / 1ps
interface mctr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_ch0;
	logic signed [15:0] out_ch1;
	logic signed [15:0] out_ch2;
	logic signed [15:0] out_ch3;

	modport source (
		output valid, out_ch0, out_ch1, out_ch2, out_ch3,
		input  ready
	);
	modport sink (
		input  valid, out_ch0, out_ch1, out_ch2, out_ch3,
		output ready
	);
endinterface

// ===== design/mctr_dp.sv =====
`timescale 1ns / 1ps
module mctr_dp import mctr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  cfg_t               cfg,
	input  logic [1:0]         channel,
	input  logic [11:0]        sample_index,
	input  logic signed [15:0] sample_value,
	input  logic signed [23:0] position_ms,
	output logic signed [15:0] out_ch0,
	output logic signed [15:0] out_ch1,
	output logic signed [15:0] out_ch2,
	output logic signed [15:0] out_ch3
);

	logic [SMP_W-1:0]        mem_q [MEM_DEPTH];
	logic [MEM_AW-1:0]       waddr;
	logic [MEM_AW-1:0]       raddr;
	logic [NDX_W-1:0]        ridx;
	logic                    wr_ok;
	logic signed [SMP_W-1:0] rd_q;
	logic                    rd_v_q;
	logic signed [SMP_W-1:0] smp_q [4];

	logic signed [23:0]      pos_q;
	logic [34:0]             plo_q;
	logic [NDX_W-1:0]        ndx_q;
	logic [FRAC_W-1:0]       frac_q;

	logic [46:0]             ph_full;
	logic [38:0]             phase;
	logic [38:0]             ph_c;
	logic [SCNT_W-1:0]       maxi;
	logic                    over;
	logic [NDX_W-1:0]        ndx_raw;

	logic signed [16:0]      cmb_val;
	logic signed [18:0]      e_val;
	logic signed [18:0]      g_val;
	logic signed [MB_W-1:0]  u_val;

	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MA_W-1:0]  inner_q;
	logic signed [MA_W-1:0]  r_q;

	logic signed [PROD_W-1:0] x_val;
	logic signed [PROD_W-18:0] s_val;
	logic [PROD_W-18:0]      m_val;
	logic [DIV_W-1:0]        div_q;
	logic [DIV_W-1:0]        quo_q;
	logic [1:0]              rem_q;
	logic                    neg_q;
	logic [9:0]              dv;
	logic [7:0]              qd;
	logic [1:0]              nr;
	logic [DIV_W-1:0]        w_val;

	logic signed [PROD_W-1:0] t_val;
	logic signed [22:0]      yq;
	logic signed [23:0]      y_full;
	logic signed [15:0]      y_sat;

	logic signed [15:0]      res_q [OUT_CH];
	logic signed [15:0]      out_q [OUT_CH];

	// Sample store: one write port for write items, one registered read port.
	assign wr_ok = (32'(channel) < MAX_CH) && (32'(sample_index) < BUF_DEPTH);
	assign waddr = MEM_AW'(channel) * MEM_AW'(BUF_DEPTH) + MEM_AW'(sample_index);
	assign ridx  = ndx_q + NDX_W'(cmd.rd_k) - NDX_W'(1);
	assign raddr = MEM_AW'(cmd.ch) * MEM_AW'(BUF_DEPTH) + MEM_AW'(ridx);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok)
			mem_q[waddr] <= sample_value;
		if (cmd.rd_en)
			rd_q <= $signed(mem_q[raddr]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_v_q <= 1'b0;
		else
			rd_v_q <= cmd.rd_en;
	end

	// The four neighbors arrive oldest first: a, b, c, d.
	always_ff @(posedge clk) begin
		if (rd_v_q) begin
			smp_q[0] <= smp_q[1];
			smp_q[1] <= smp_q[2];
			smp_q[2] <= smp_q[3];
			smp_q[3] <= rd_q;
		end
	end

	// Phase from the two partial products of position and scale.
	assign ph_full = 47'(plo_q) + {prod_q[34:0], 12'b0};
	assign phase   = ph_full[46:8];
	assign maxi    = eff_count(cfg.sample_count) - SCNT_W'(3);
	assign over    = phase > {10'b0, maxi, 16'b0};
	assign ph_c    = (pos_q[23] || over) ? '0 : phase;
	assign ndx_raw = ph_c[16 +: NDX_W];

	always_ff @(posedge clk) begin
		if (cmd.ld_pos)
			pos_q <= position_ms;
		if (cmd.plo_ld)
			plo_q <= prod_q[34:0];
		if (cmd.ph_ld) begin
			if (ndx_raw == '0) begin
				ndx_q  <= NDX_W'(1);
				frac_q <= '0;
			end else begin
				ndx_q  <= ndx_raw;
				frac_q <= ph_c[FRAC_W-1:0];
			end
		end
	end

	// Cubic coefficients from the neighbors.
	assign cmb_val = 17'(smp_q[2]) - 17'(smp_q[1]);
	assign e_val   = 19'(smp_q[3]) - 19'(smp_q[0]) - 19'(cmb_val) - (19'(cmb_val) <<< 1);
	assign g_val   = 19'(smp_q[3]) + (19'(smp_q[0]) <<< 1) - 19'(smp_q[1])
		- (19'(smp_q[1]) <<< 1);
	assign u_val   = MB_W'(17'h10000 - {1'b0, frac_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_PH_LO: begin
				mul_a = MA_W'({1'b0, pos_q[22:0]});
				mul_b = MB_W'(cfg.ms_scale[11:0]);
			end
			MUL_PH_HI: begin
				mul_a = MA_W'({1'b0, pos_q[22:0]});
				mul_b = MB_W'(cfg.ms_scale[23:12]);
			end
			MUL_EF: begin
				mul_a = MA_W'(e_val);
				mul_b = MB_W'(frac_q);
			end
			MUL_INNER: begin
				mul_a = inner_q;
				mul_b = u_val;
			end
			MUL_RF: begin
				mul_a = r_q;
				mul_b = MB_W'(frac_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.inner_ld)
			inner_q <= $signed(prod_q[MA_W-1:0]) + (MA_W'(g_val) <<< 16);
	end

	// Floor division by 6 * 2^16: the shift takes 2^17, the byte loop takes 3.
	// A negative dividend is complemented so that the loop sees only magnitudes.
	assign x_val = PROD_W'(CORR_RND) - prod_q;
	assign s_val = x_val[PROD_W-1:17];
	assign m_val = s_val[PROD_W-18] ? ~s_val : s_val;

	assign dv = {rem_q, div_q[DIV_W-1 -: 8]};
	assign qd = 8'((20'(dv) * 20'(DIV3_MUL)) >> DIV3_SH);
	assign nr = 2'(dv - 10'(qd) * 10'd3);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_q <= DIV_W'(m_val);
			rem_q <= '0;
			neg_q <= s_val[PROD_W-18];
		end else if (cmd.div_step) begin
			div_q <= div_q << 8;
			quo_q <= {quo_q[DIV_W-9:0], qd};
			rem_q <= nr;
		end
	end

	assign w_val = neg_q ? ~quo_q : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.r_ld)
			r_q <= (MA_W'(cmb_val) <<< 16) + MA_W'($signed(w_val));
	end

	// Final rounding to an integer and saturation.
	assign t_val  = prod_q + (PROD_W'(1) <<< 31);
	assign yq     = t_val[PROD_W-1:32];
	assign y_full = 24'(smp_q[1]) + 24'(yq);

	always_comb begin
		if (y_full > 24'sd32767)
			y_sat = 16'sh7FFF;
		else if (y_full < -24'sd32768)
			y_sat = -16'sh8000;
		else
			y_sat = 16'(y_full);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_res) begin
			for (int k = 0; k < OUT_CH; k++)
				res_q[k] <= '0;
		end else if (cmd.y_ld) begin
			res_q[2'(cmd.ch)] <= y_sat;
		end
		if (cmd.out_load) begin
			for (int k = 0; k < OUT_CH; k++)
				out_q[k] <= res_q[k];
		end
	end

	assign out_ch0 = out_q[0];
	assign out_ch1 = out_q[1];
	assign out_ch2 = out_q[2];
	assign out_ch3 = out_q[3];

endmodule

// ===== design/mctr_ctrl.sv =====
`timescale 1ns / 1ps
module mctr_ctrl import mctr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	input  logic    item_op,
	output logic    item_ready,
	output logic    res_valid,
	input  logic    res_ready,
	output dp_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PH0  = 4'd1;
	localparam logic [3:0] S_PH1  = 4'd2;
	localparam logic [3:0] S_PH2  = 4'd3;
	localparam logic [3:0] S_CH   = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_E    = 4'd6;
	localparam logic [3:0] S_M1   = 4'd7;
	localparam logic [3:0] S_M2   = 4'd8;
	localparam logic [3:0] S_M3   = 4'd9;
	localparam logic [3:0] S_DV   = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_R    = 4'd12;
	localparam logic [3:0] S_M4   = 4'd13;
	localparam logic [3:0] S_Y    = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	logic [3:0]      state_q, state_d;
	logic [2:0]      cnt_q, cnt_d;
	logic [CH_W-1:0] ch_q, ch_d;
	logic            out_valid_q;
	logic            play_ok;
	logic [2:0]      nch;
	logic            ch_active;
	logic            ch_last;
	logic            out_free;

	assign play_ok   = cfg.playable && (eff_count(cfg.sample_count) >= SCNT_W'(4));
	assign nch       = (int'(cfg.channel_count) > MAX_CH) ? 3'(MAX_CH) : cfg.channel_count;
	assign ch_active = (3'(ch_q) < nch) && cfg.channel_present[2'(ch_q)];
	assign ch_last   = ch_q == CH_W'(MAX_CH - 1);
	assign out_free  = !out_valid_q || res_ready;

	assign item_ready = state_q == S_IDLE;
	assign res_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ch_d    = ch_q;
		cmd     = '0;
		cmd.ch  = ch_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (item_op == OP_WRITE) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.ld_pos = 1'b1;
						state_d    = S_PH0;
					end
				end
			end
			S_PH0: begin
				cmd.mul_sel = MUL_PH_LO;
				cmd.clr_res = 1'b1;
				state_d     = S_PH1;
			end
			S_PH1: begin
				cmd.mul_sel = MUL_PH_HI;
				cmd.plo_ld  = 1'b1;
				state_d     = S_PH2;
			end
			S_PH2: begin
				cmd.ph_ld = 1'b1;
				ch_d      = '0;
				state_d   = play_ok ? S_CH : S_DONE;
			end
			S_CH: begin
				if (ch_active) begin
					cnt_d   = '0;
					state_d = S_RD;
				end else if (ch_last) begin
					state_d = S_DONE;
				end else begin
					ch_d = ch_q + CH_W'(1);
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_k  = cnt_q[1:0];
				if (cnt_q == 3'd3)
					state_d = S_E;
				else
					cnt_d = cnt_q + 3'd1;
			end
			S_E: begin
				state_d = S_M1;
			end
			S_M1: begin
				cmd.mul_sel = MUL_EF;
				state_d     = S_M2;
			end
			S_M2: begin
				cmd.inner_ld = 1'b1;
				state_d      = S_M3;
			end
			S_M3: begin
				cmd.mul_sel = MUL_INNER;
				state_d     = S_DV;
			end
			S_DV: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 3'(DIV_STEPS - 1))
					state_d = S_R;
				else
					cnt_d = cnt_q + 3'd1;
			end
			S_R: begin
				cmd.r_ld = 1'b1;
				state_d  = S_M4;
			end
			S_M4: begin
				cmd.mul_sel = MUL_RF;
				state_d     = S_Y;
			end
			S_Y: begin
				cmd.y_ld = 1'b1;
				if (ch_last) begin
					state_d = S_DONE;
				end else begin
					ch_d    = ch_q + CH_W'(1);
					state_d = S_CH;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ch_q    <= ch_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/multichannel_cubic_table_reader.sv =====
`timescale 1ns / 1ps
// Multichannel cubic table reader. A write beat stores one 16-bit sample of
// one channel. A play beat turns a position in milliseconds into a read
// phase and returns one result beat holding a four-point cubic
// interpolation for each channel that is in use and present. When the
// buffer is not playable, the channel work is skipped. The time a play beat
// takes is set by the single read port of the sample store (four reads per
// channel), the one shared multiplier (two products per beat for the phase
// and three per channel) and the byte-serial divide by three of the
// correction term. A new beat is taken while a finished result still waits
// in the output register. The sample store is not cleared at reset; entries
// must be written before they are played.
module multichannel_cubic_table_reader import mctr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mctr_in_if.sink               item,
	mctr_out_if.source            result
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MS_SCALE:        cfg_q.ms_scale        <= cfg_data;
				REG_SAMPLE_COUNT:    cfg_q.sample_count    <= cfg_data[SCNT_W-1:0];
				REG_PLAYABLE:        cfg_q.playable        <= cfg_data[0];
				REG_CHANNEL_COUNT:   cfg_q.channel_count   <= cfg_data[2:0];
				REG_CHANNEL_PRESENT: cfg_q.channel_present <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	mctr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item.valid),
		.item_op    (item.op),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.cmd        (cmd)
	);

	mctr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_q),
		.channel      (item.channel),
		.sample_index (item.sample_index),
		.sample_value (item.sample_value),
		.position_ms  (item.position_ms),
		.out_ch0      (result.out_ch0),
		.out_ch1      (result.out_ch1),
		.out_ch2      (result.out_ch2),
		.out_ch3      (result.out_ch3)
	);

	// A play beat keeps the input closed until its result is staged.
	a_play_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.op == OP_PLAY |=> !item.ready)
		else $error("input accepted right after a play beat");

	// The output register is only reloaded once its beat has gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !result.valid || result.ready)
		else $error("pending result overwritten");

	// No write can reach the store while neighbors are being read.
	a_read_closed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !item.ready)
		else $error("input open during sample reads");

	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.rd_en, cmd.div_step, cmd.y_ld, cmd.wr_en}))
		else $error("datapath phases overlap");

endmodule

// ===== sim/multichannel_cubic_table_reader_checker.sv =====
`timescale 1ns / 1ps
module multichannel_cubic_table_reader_checker import mctr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mctr_in_if                    item,
	mctr_out_if                   result,
	output int                    mismatches,
	output int                    frames_pending
);

	localparam longint UNIT = 64'sd65536;

	typedef logic [OUT_CH-1:0][SMP_W-1:0] frame_t;

	cfg_t                    settings;
	logic signed [SMP_W-1:0] sample_mem [MEM_DEPTH];
	frame_t                  expected_frames [$];

	function automatic longint quot_floor(input longint n, input longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint quot_round(input longint n, input longint d);
		return quot_floor(n + d / 2, d);
	endfunction

	// Lagrange cubic through a..d at fraction f (16 fraction bits), saturated.
	function automatic longint cubic_point(input longint a, input longint b, input longint c,
			input longint d, input longint f);
		longint cmb, inner, q, r, y;
		cmb   = c - b;
		inner = (d - a - 3 * cmb) * f + (d + 2 * a - 3 * b) * UNIT;
		q     = 6 * cmb * UNIT * UNIT - inner * (UNIT - f);
		r     = quot_round(q, 6 * UNIT);
		y     = quot_round(b * UNIT * UNIT + r * f, UNIT * UNIT);
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return y;
	endfunction

	function automatic frame_t predict_frame(input logic [23:0] pos);
		frame_t frame;
		longint count_eff, phase, ndx, frac, base;
		int     nch;
		frame = '0;
		count_eff = (settings.sample_count > BUF_DEPTH) ? BUF_DEPTH : settings.sample_count;
		if (!settings.playable || count_eff < 4)
			return frame;
		phase = 0;
		if (!pos[23]) begin
			phase = (longint'(pos) * longint'(settings.ms_scale)) >>> 8;
			if (phase > ((count_eff - 3) <<< 16))
				phase = 0;
		end
		ndx  = phase >>> 16;
		frac = phase & (UNIT - 1);
		if (ndx < 1) begin
			ndx  = 1;
			frac = 0;
		end
		nch = (settings.channel_count > MAX_CH) ? MAX_CH : settings.channel_count;
		for (int c = 0; c < OUT_CH; c++) begin
			if (c < nch && settings.channel_present[c]) begin
				base     = c * BUF_DEPTH + ndx;
				frame[c] = SMP_W'(cubic_point(sample_mem[base - 1], sample_mem[base],
					sample_mem[base + 1], sample_mem[base + 2], frac));
			end
		end
		return frame;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_t got, want;
		if (!arst_n) begin
			settings = CFG_RESET;
			expected_frames.delete();
			mismatches     = 0;
			frames_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MS_SCALE:        settings.ms_scale = cfg_data[23:0];
					REG_SAMPLE_COUNT:    settings.sample_count = cfg_data[SCNT_W-1:0];
					REG_PLAYABLE:        settings.playable = cfg_data[0];
					REG_CHANNEL_COUNT:   settings.channel_count = cfg_data[2:0];
					REG_CHANNEL_PRESENT: settings.channel_present = cfg_data[3:0];
					default: ;
				endcase
			end
			// The result beat is handled before the item beat of the same edge,
			// since a play beat cannot be answered in the cycle it is taken.
			if (result.valid && result.ready) begin
				got = {result.out_ch3, result.out_ch2, result.out_ch1, result.out_ch0};
				if (expected_frames.size() == 0) begin
					$error("result beat arrived with no play beat waiting");
					mismatches++;
				end else begin
					want = expected_frames.pop_front();
					for (int k = 0; k < OUT_CH; k++) begin
						if (got[k] !== want[k]) begin
							$error("out_ch%0d: expected %0d, actual %0d", k,
								$signed(want[k]), $signed(got[k]));
							mismatches++;
						end
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.op == OP_WRITE)
					sample_mem[item.channel * BUF_DEPTH + item.sample_index] = item.sample_value;
				else
					expected_frames.push_back(predict_frame(item.position_ms));
			end
			frames_pending = expected_frames.size();
		end
	end

endmodule

// ===== sim/multichannel_cubic_table_reader_tb.sv =====
`timescale 1ns / 1ps
module multichannel_cubic_table_reader_tb;
	import mctr_pkg::*;

	// Indexes from here up have no register behind them.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 800;
	// Entries of each channel that are written before the buffer is made playable.
	localparam int FILL_DEPTH    = 64;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    frames_pending;
	int                    burst_left;
	bit                    hold_request;
	logic [23:0]           scale_now;
	logic [SCNT_W-1:0]     count_now;

	mctr_in_if  item_ch ();
	mctr_out_if result_ch ();

	multichannel_cubic_table_reader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	multichannel_cubic_table_reader_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item           (item_ch),
		.result         (result_ch),
		.mismatches     (mismatches),
		.frames_pending (frames_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// One beat on the item channel. Gaps are inserted only between bursts.
	task automatic offer(input logic op, input logic [1:0] ch, input logic [11:0] idx,
			input logic [15:0] val, input logic [23:0] pos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90) : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 32);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_ch.valid        <= 1'b1;
		item_ch.op           <= op;
		item_ch.channel      <= ch;
		item_ch.sample_index <= idx;
		item_ch.sample_value <= val;
		item_ch.position_ms  <= pos;
		do @(posedge clk); while (!item_ch.ready);
		burst_left--;
	endtask

	task automatic play_at(input logic [23:0] pos);
		offer(OP_PLAY, 2'($urandom()), 12'($urandom()), 16'($urandom()), pos);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (frames_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes every register; upper data bits carry noise half of the time.
	task automatic apply_settings(input logic [23:0] scale, input logic [SCNT_W-1:0] n_samples,
			input logic play_en, input logic [2:0] nch, input logic [3:0] present);
		logic [CFG_DATA_W-1:0] noise;
		noise = ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom()) : '0;
		cfg_we    <= 1'b1;
		cfg_index <= REG_MS_SCALE;
		cfg_data  <= scale;
		@(posedge clk);
		cfg_index <= REG_SAMPLE_COUNT;
		cfg_data  <= {noise[CFG_DATA_W-1:SCNT_W], n_samples};
		@(posedge clk);
		cfg_index <= REG_PLAYABLE;
		cfg_data  <= {noise[CFG_DATA_W-1:1], play_en};
		@(posedge clk);
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data  <= {noise[CFG_DATA_W-1:3], nch};
		@(posedge clk);
		cfg_index <= REG_CHANNEL_PRESENT;
		cfg_data  <= {noise[CFG_DATA_W-1:4], present};
		@(posedge clk);
		if ($urandom_range(0, 3) == 0) begin
			cfg_index <= REG_SPARE + CFG_IDX_W'($urandom_range(0, 2));
			cfg_data  <= CFG_DATA_W'($urandom());
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		scale_now = scale;
		count_now = n_samples;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// Mostly positions that land inside the filled part of the buffer. When the
	// count reaches past the filled part, stray positions are kept negative.
	function automatic logic [23:0] pick_position();
		longint eff, lim, span;
		eff = (count_now > BUF_DEPTH) ? BUF_DEPTH : count_now;
		lim = (eff > FILL_DEPTH) ? FILL_DEPTH : eff;
		if (scale_now == 0 || eff < 4 || $urandom_range(0, 9) == 0) begin
			if (eff > FILL_DEPTH)
				return {1'b1, 23'($urandom())};
			return 24'($urandom());
		end
		span = ((lim - 3) <<< 24) / scale_now;
		if (span > 24'h7FFFFF)
			span = 24'h7FFFFF;
		case ($urandom_range(0, 9))
			0:       return 24'(span);
			1:       return 24'(span + 1);
			2:       return 24'($urandom_range(0, (span < 255) ? int'(span) : 255));
			default: return 24'($urandom_range(0, int'(span)));
		endcase
	endfunction

	initial begin : receiver
		int       hold_left;
		int       mode_left;
		int       stall_left;
		rx_mode_t mode;
		hold_left  = 0;
		mode_left  = 0;
		stall_left = 0;
		mode       = RX_OPEN;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:   result_ch.ready <= 1'b1;
					RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: result_ch.ready <= (mode_left % 4 == 0);
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							result_ch.ready <= 1'b0;
						end else begin
							result_ch.ready <= 1'b1;
							if ($urandom_range(0, 7) == 0)
								stall_left = $urandom_range(5, 40);
						end
					end
				endcase
			end
		end
	end

	initial begin
		logic [23:0]       scale;
		logic [SCNT_W-1:0] n_samples;
		logic              play_en;
		logic [2:0]        nch;
		logic [3:0]        present;
		logic [15:0]       val;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		item_ch.valid        <= 1'b0;
		item_ch.op           <= OP_WRITE;
		item_ch.channel      <= '0;
		item_ch.sample_index <= '0;
		item_ch.sample_value <= '0;
		item_ch.position_ms  <= '0;
		burst_left   = 0;
		hold_request = 1'b0;
		scale_now    = CFG_RESET.ms_scale;
		count_now    = CFG_RESET.sample_count;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the buffer is not playable.
		play_at(24'h000180);

		// Fill the start of every channel so every later read hits written data.
		// The first eight entries of each channel hold full-scale swings
		// that drive the interpolation past both rails.
		for (int ch = 0; ch < MAX_CH; ch++) begin
			for (int idx = 0; idx < FILL_DEPTH; idx++) begin
				if (idx < 8)
					val = (idx == 0 || idx == 3 || idx == 5 || idx == 6) ? 16'h8000 : 16'h7FFF;
				else
					val = pick_sample();
				offer(OP_WRITE, 2'(ch), 12'(idx), val, 24'($urandom()));
			end
		end
		drain();

		// Unit scale: position bits map straight onto index and fraction.
		apply_settings(24'h010000, SCNT_W'(FILL_DEPTH), 1'b1, 3'd4, 4'hF);
		play_at(24'h000180);
		play_at(24'h000580);
		play_at(24'h000000);
		play_at(24'h000080);
		play_at(24'h800000);
		play_at(24'hFFFFFF);
		play_at(24'((FILL_DEPTH - 3) << 8));
		play_at(24'(((FILL_DEPTH - 3) << 8) + 1));
		play_at(24'h7FFFFF);
		play_at(24'h000201);
		play_at(24'h0002FF);
		drain();

		// Widest scale, oversized count and channel count, sparse channels.
		apply_settings(24'hFFFFFF, 13'h1FFF, 1'b1, 3'd7, 4'hA);
		play_at(24'h000001);
		play_at(24'h000010);
		play_at(24'h00003C);
		play_at(pick_position());
		drain();

		// Too few samples to play.
		apply_settings(24'h010000, 13'd3, 1'b1, 3'd4, 4'hF);
		play_at(24'h000100);
		drain();

		// Zero scale always reads at the first interior sample.
		apply_settings(24'd0, 13'd4, 1'b1, 3'd4, 4'hF);
		play_at(24'h123456);
		drain();

		apply_settings(24'h010000, 13'd4, 1'b1, 3'd0, 4'hF);
		play_at(24'h000100);
		drain();

		apply_settings(24'h010000, 13'd4, 1'b1, 3'd4, 4'h0);
		play_at(24'h000100);
		drain();

		for (int phase_no = 0; phase_no < 12; phase_no++) begin
			case ($urandom_range(0, 5))
				0:       scale = 24'd0;
				1:       scale = 24'hFFFFFF;
				2:       scale = 24'h010000;
				3:       scale = CFG_RESET.ms_scale;
				default: scale = 24'($urandom_range(1, 24'hFFFFFF));
			endcase
			case ($urandom_range(0, 7))
				0:       n_samples = SCNT_W'($urandom_range(0, 3));
				1:       n_samples = SCNT_W'(4);
				2:       n_samples = SCNT_W'(BUF_DEPTH);
				3:       n_samples = SCNT_W'($urandom_range(BUF_DEPTH + 1, 8191));
				default: n_samples = SCNT_W'($urandom_range(4, BUF_DEPTH));
			endcase
			play_en = ($urandom_range(0, 7) != 0);
			nch     = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 4));
			present = ($urandom_range(0, 1) == 1) ? 4'hF : 4'($urandom());
			apply_settings(scale, n_samples, play_en, nch, present);
			repeat (60) begin
				if ($urandom_range(0, 99) < 65)
					play_at(pick_position());
				else
					offer(OP_WRITE, 2'($urandom()), 12'($urandom()), pick_sample(),
						24'($urandom()));
			end
			drain();
		end

		// Hold the result side off long enough for the block to back up.
		apply_settings(24'h010000, SCNT_W'(FILL_DEPTH), 1'b1, 3'd4, 4'hF);
		hold_request = 1'b1;
		repeat (40) play_at(pick_position());
		drain();

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== multichannel_cubic_table_reader.f =====
design/mctr_pkg.sv
design/mctr_in_if.sv
design/mctr_out_if.sv
design/mctr_dp.sv
design/mctr_ctrl.sv
design/multichannel_cubic_table_reader.sv
sim/multichannel_cubic_table_reader_checker.sv
sim/multichannel_cubic_table_reader_tb.sv
